// ===== sv/assert_macros.svh =====
// Assertion macros shared by the totient RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/etot_pkg.sv =====
// Shared constants for the totient block.
`default_nettype none

package etot_pkg;

  // Width of the number and totient fields on the channels.
  localparam int unsigned DATA_W = 32;

endpackage

`default_nettype wire

// ===== sv/etot_ifs.sv =====
// Valid/ready channel interfaces for the number input and the totient output.
`default_nettype none

interface etot_num_if;
  logic                        valid;
  logic                        ready;
  logic [etot_pkg::DATA_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface etot_tot_if;
  logic                        valid;
  logic                        ready;
  logic [etot_pkg::DATA_W-1:0] totient;

  modport source (output valid, output totient, input ready);
  modport sink   (input valid, input totient, output ready);
endinterface

`default_nettype wire

// ===== sv/etot_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"

module etot_div #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     acc_q, acc_d;     // dividend bits out on top, quotient bits in below
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     divisor_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [W:0]       shifted;
  logic [W:0]       trial;

  assign shifted = {rem_q, acc_q[W-1]};
  assign trial   = shifted - {1'b0, divisor_q};

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(W);
    end else if (cnt_q != '0) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        acc_d = {acc_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        acc_d = {acc_q[W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

  `ASSERT_AR(a_rem_below_divisor, clk_i, rst_ni, !done_q || (rem_q < divisor_q),
             "divider remainder not below divisor")
  `ASSERT_NEXT(a_start_loads_count, clk_i, rst_ni, start_i, cnt_q == CNT_W'(W),
               "divider start did not load the bit count")

endmodule

`default_nettype wire

// ===== sv/euler_totient.sv =====
// Euler totient by trial division over a shared bit-serial divider.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    number  [31:0] unsigned
//   out_o    out  valid/ready    totient [31:0] unsigned
//
// One number is worked on at a time; in_i.ready is high only when idle.
// Each trial division runs the bit-serial divider over NUM_WIDTH bits; an
// even input is first shifted right once per trailing zero. Worst case for
// 32 bits is a prime near 2^32, with about 32768 odd divisors to try.
// The finished totient sits in an output register, so a new number is
// taken while it waits on out_o.ready. rst_ni clears the control state.
`default_nettype none
`include "assert_macros.svh"

module euler_totient #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  etot_num_if.sink    in_i,
  etot_tot_if.source  out_o
);

  localparam int unsigned W = NUM_WIDTH;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a number
  localparam logic [2:0] S_HALVE = 3'd1;  // shifting out factors of two
  localparam logic [2:0] S_DIV_M = 3'd2;  // m / d: bound check and factor strip
  localparam logic [2:0] S_DIV_R = 3'd3;  // res / d for the update
  localparam logic [2:0] S_DIV_F = 3'd4;  // res / m for the leftover prime
  localparam logic [2:0] S_PUSH  = 3'd5;  // hand result to the output register

  logic [2:0]                  state_q, state_d;
  logic [W-1:0]                m_q, m_d;      // remaining cofactor
  logic [W-1:0]                res_q, res_d;  // running totient
  logic [W-1:0]                d_q, d_d;      // odd trial divisor
  logic                        strip_q, strip_d;
  logic                        start_q, start_d;
  logic                        out_valid_q, out_valid_d;
  logic [etot_pkg::DATA_W-1:0] tot_q, tot_d;

  logic         in_xfer;
  logic [W-1:0] n_in;
  logic [W-1:0] div_a, div_b;
  logic         div_done;
  logic [W-1:0] div_quot, div_rem;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign n_in       = W'(in_i.number);  // drops bits above the working width

  // Operands follow the state the sequencer has just entered.
  assign div_a = (state_q == S_DIV_M) ? m_q : res_q;
  assign div_b = (state_q == S_DIV_F) ? m_q : d_q;

  etot_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    res_d       = res_q;
    d_d         = d_q;
    strip_d     = strip_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q;
    tot_d       = tot_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          m_d     = n_in;
          res_d   = n_in;
          d_d     = W'(3);
          strip_d = 1'b0;
          if (n_in == '0) begin
            state_d = S_PUSH;
          end else if (!n_in[0]) begin
            state_d = S_HALVE;
          end else begin
            state_d = S_DIV_M;
            start_d = 1'b1;
          end
        end
      end
      S_HALVE: begin
        m_d = m_q >> 1;
        if (m_q[1]) begin
          // cofactor now odd: apply the update for two
          res_d   = res_q - (res_q >> 1);
          state_d = S_DIV_M;
          start_d = 1'b1;
        end
      end
      S_DIV_M: begin
        if (div_done) begin
          if (!strip_q) begin
            if (d_q > div_quot) begin
              // d*d > m: only a leftover prime can remain
              if (m_q > W'(1)) begin
                state_d = S_DIV_F;
                start_d = 1'b1;
              end else begin
                state_d = S_PUSH;
              end
            end else if (div_rem == '0) begin
              m_d     = div_quot;
              strip_d = 1'b1;
              start_d = 1'b1;
            end else begin
              d_d     = d_q + W'(2);
              start_d = 1'b1;
            end
          end else if (div_rem == '0) begin
            m_d     = div_quot;
            start_d = 1'b1;
          end else begin
            // factor fully removed, now res -= res / d
            strip_d = 1'b0;
            state_d = S_DIV_R;
            start_d = 1'b1;
          end
        end
      end
      S_DIV_R: begin
        if (div_done) begin
          res_d   = res_q - div_quot;
          d_d     = d_q + W'(2);
          state_d = S_DIV_M;
          start_d = 1'b1;
        end
      end
      S_DIV_F: begin
        if (div_done) begin
          res_d   = res_q - div_quot;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          tot_d       = etot_pkg::DATA_W'(res_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      strip_q     <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      strip_q     <= strip_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    res_q <= res_d;
    d_q   <= d_d;
    tot_q <= tot_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.totient = tot_q;

  `ASSERT_AR(a_done_in_div_state, clk_i, rst_ni,
             !div_done || (state_q == S_DIV_M) || (state_q == S_DIV_R) || (state_q == S_DIV_F),
             "divider finished outside a division state")
  `ASSERT_AR(a_halve_even, clk_i, rst_ni, (state_q != S_HALVE) || !m_q[0],
             "halving an odd cofactor")
  `ASSERT_AR(a_divisor_odd, clk_i, rst_ni,
             !((state_q == S_DIV_M) || (state_q == S_DIV_R)) || d_q[0],
             "trial divisor is even")
  `ASSERT_AR(a_leftover_prime, clk_i, rst_ni, (state_q != S_DIV_F) || (m_q > W'(1)),
             "leftover update with cofactor not above one")

endmodule

`default_nettype wire
